>>> rtl/mtsed_pkg.sv
package mtsed_pkg;

    localparam int SLOTS_DEF   = 10;
    localparam int SCALE_SHIFT = 12;
    localparam int POS_W       = 16;
    localparam int PROD_W      = SCALE_SHIFT + POS_W;
    localparam int SCALE_W     = 29;
    localparam int VALUE_W     = 32;
    localparam int KIND_W      = 5;
    localparam int CODE_W      = 10;
    localparam int CONTACT_W   = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [KIND_W-1:0] EVK_SYNC = 5'd0;
    localparam logic [KIND_W-1:0] EVK_KEY  = 5'd1;
    localparam logic [KIND_W-1:0] EVK_ABS  = 5'd3;

    localparam logic [CODE_W-1:0] C_BTN_TOUCH = 10'd330;
    localparam logic [CODE_W-1:0] C_ABS_X     = 10'd0;
    localparam logic [CODE_W-1:0] C_ABS_Y     = 10'd1;
    localparam logic [CODE_W-1:0] C_MT_SLOT   = 10'd47;
    localparam logic [CODE_W-1:0] C_MT_POS_X  = 10'd53;
    localparam logic [CODE_W-1:0] C_MT_POS_Y  = 10'd54;
    localparam logic [CODE_W-1:0] C_MT_TRACK  = 10'd57;

    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MT_MODE = 2'd2;

    localparam logic [1:0] TS_RELEASED = 2'd0;
    localparam logic [1:0] TS_PRESSED  = 2'd1;
    localparam logic [1:0] TS_MOTION   = 2'd2;

    typedef enum logic [1:0] {
        ACT_IDLE     = 2'd0,
        ACT_POSITION = 2'd1,
        ACT_RELEASED = 2'd2,
        ACT_PRESSED  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic walk;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic sync_go;
        logic hit;
        logic idx_end;
        logic out_free;
    } t_status;

endpackage

>>> rtl/multitouch_slot_event_decoder_core.sv
// An event is accepted, then applied in an update state; the input is ready again after that.
// A sync with pending data then walks slots 1..SLOTS at one slot per cycle, holding on a slot
// whose report waits on a full output register; the input is not ready during the walk, so a
// new event is taken only once the previous one has been fully handled.
// Reset (synchronous, active low) clears all slots, slot pointer, flags, scales and mode.
module multitouch_slot_event_decoder_core #(
    parameter int SLOTS = mtsed_pkg::SLOTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mtsed_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mtsed_pkg::SCALE_W-1:0]        i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mtsed_pkg::KIND_W-1:0]         i_kind,
    input  logic [mtsed_pkg::CODE_W-1:0]         i_event_code,
    input  logic signed [mtsed_pkg::VALUE_W-1:0] i_event_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mtsed_pkg::CONTACT_W-1:0]      o_contact_index,
    output logic [1:0]                           o_touch_state,
    output logic [mtsed_pkg::POS_W-1:0]          o_pos_x,
    output logic [mtsed_pkg::POS_W-1:0]          o_pos_y,
    output logic                                 o_last_in_run
);
    import mtsed_pkg::*;

    t_cmd    cmd;
    t_status sts;

    mtsed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mtsed_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_event_code    (i_event_code),
        .i_event_value   (i_event_value),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_contact_index (o_contact_index),
        .o_touch_state   (o_touch_state),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_last_in_run   (o_last_in_run)
    );

endmodule

>>> rtl/mtsed_ctrl.sv
module mtsed_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mtsed_pkg::t_status i_sts,
    output mtsed_pkg::t_cmd    o_cmd
);
    import mtsed_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.sync_go) begin
                    n_state = ST_WALK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (!i_sts.hit || i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    o_cmd.emit = i_sts.hit;
                    if (i_sts.idx_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ST_EXEC))
        else $error("capture not followed by exec");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("emit into a full output register");
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.exec, o_cmd.walk}))
        else $error("overlapping commands");
`endif

endmodule

>>> rtl/mtsed_datapath.sv
module mtsed_datapath #(
    parameter int SLOTS = mtsed_pkg::SLOTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mtsed_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mtsed_pkg::SCALE_W-1:0]        i_cfg_data,
    input  logic [mtsed_pkg::KIND_W-1:0]         i_kind,
    input  logic [mtsed_pkg::CODE_W-1:0]         i_event_code,
    input  logic signed [mtsed_pkg::VALUE_W-1:0] i_event_value,
    input  mtsed_pkg::t_cmd                      i_cmd,
    output mtsed_pkg::t_status                   o_sts,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [mtsed_pkg::CONTACT_W-1:0]      o_contact_index,
    output logic [1:0]                           o_touch_state,
    output logic [mtsed_pkg::POS_W-1:0]          o_pos_x,
    output logic [mtsed_pkg::POS_W-1:0]          o_pos_y,
    output logic                                 o_last_in_run
);
    import mtsed_pkg::*;

    localparam int SW = (SLOTS + 1 > 1) ? $clog2(SLOTS + 1) : 1;

    logic [SCALE_W-1:0] r_x_scale;
    logic [SCALE_W-1:0] r_y_scale;
    logic               r_mt_mode;

    logic [KIND_W-1:0]  r_kind;
    logic [CODE_W-1:0]  r_code;
    logic [VALUE_W-1:0] r_val;

    logic [POS_W-1:0] r_sx  [0:SLOTS];
    logic [POS_W-1:0] r_sy  [0:SLOTS];
    t_action          r_act [0:SLOTS];
    logic [POS_W-1:0] n_sx  [0:SLOTS];
    logic [POS_W-1:0] n_sy  [0:SLOTS];
    t_action          n_act [0:SLOTS];

    logic [SW-1:0] r_cur_slot, n_cur_slot;
    logic          r_inv, n_inv;
    logic          r_pend, n_pend;
    logic [SW-1:0] r_walk_idx, n_walk_idx;

    logic                 r_out_valid;
    logic [CONTACT_W-1:0] r_contact;
    logic [1:0]           r_tstate;
    logic [POS_W-1:0]     r_px;
    logic [POS_W-1:0]     r_py;
    logic                 r_last;

    logic [SW-1:0]     rd_idx;
    t_action           rd_act;
    logic              val_nz;
    logic              val_neg;
    logic              pos_x_hit;
    logic              pos_y_hit;
    logic              slot_ok;
    logic [PROD_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_b;
    logic [PROD_W-1:0] prod;
    logic [POS_W-1:0]  scaled;
    logic              above;
    logic [SW-1:0]     idx_m1;
    logic [1:0]        emit_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale <= '0;
            r_y_scale <= '0;
            r_mt_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_X_SCALE: r_x_scale <= i_cfg_data;
                CFG_Y_SCALE: r_y_scale <= i_cfg_data;
                CFG_MT_MODE: r_mt_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_code <= i_event_code;
            r_val  <= $unsigned(i_event_value);
        end
    end

    assign rd_idx    = i_cmd.walk ? r_walk_idx : r_cur_slot;
    assign rd_act    = r_act[rd_idx];
    assign val_nz    = |r_val;
    assign val_neg   = r_val[VALUE_W-1];
    assign pos_x_hit = ((r_code == C_ABS_X) && !r_mt_mode) || (r_code == C_MT_POS_X);
    assign pos_y_hit = ((r_code == C_ABS_Y) && !r_mt_mode) || (r_code == C_MT_POS_Y);
    assign slot_ok   = (&r_val) || (!val_neg && (r_val < VALUE_W'(SLOTS)));
    assign mul_a     = pos_y_hit ? r_y_scale[PROD_W-1:0] : r_x_scale[PROD_W-1:0];
    assign mul_b     = r_val[PROD_W-1:0];
    assign prod      = mul_a * mul_b;
    assign scaled    = prod[PROD_W-1:SCALE_SHIFT];
    assign idx_m1    = r_walk_idx - SW'(1);

    always_comb begin
        above = 1'b0;
        for (int j = 1; j <= SLOTS; j++) begin
            if ((SW'(j) > r_walk_idx) && (r_act[j] != ACT_IDLE)) begin
                above = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (rd_act)
            ACT_RELEASED: emit_state = TS_RELEASED;
            ACT_PRESSED:  emit_state = TS_PRESSED;
            default:      emit_state = TS_MOTION;
        endcase
    end

    always_comb begin
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_act      = r_act;
        n_cur_slot = r_cur_slot;
        n_inv      = r_inv;
        n_pend     = r_pend;
        n_walk_idx = r_walk_idx;
        if (i_cmd.exec) begin
            case (r_kind)
                EVK_KEY: begin
                    if (r_code == C_BTN_TOUCH) begin
                        n_pend = 1'b1;
                        if (!r_inv) begin
                            n_act[r_cur_slot] = val_nz ? ACT_PRESSED : ACT_RELEASED;
                        end
                        if (!val_nz) begin
                            n_cur_slot = '0;
                            n_inv      = 1'b0;
                        end else if (!r_inv && (r_cur_slot == '0)) begin
                            n_sx[1]    = r_sx[0];
                            n_sy[1]    = r_sy[0];
                            n_act[1]   = ACT_PRESSED;
                            n_cur_slot = SW'(1);
                        end
                    end
                end
                EVK_ABS: begin
                    if (pos_x_hit || pos_y_hit) begin
                        n_pend = 1'b1;
                        if (!r_inv) begin
                            if (pos_x_hit) begin
                                n_sx[r_cur_slot] = scaled;
                            end else begin
                                n_sy[r_cur_slot] = scaled;
                            end
                            if (rd_act == ACT_IDLE) begin
                                n_act[r_cur_slot] = ACT_POSITION;
                            end
                        end
                    end else if (r_code == C_MT_SLOT) begin
                        if (slot_ok) begin
                            n_cur_slot = r_val[SW-1:0] + SW'(1);
                            n_inv      = 1'b0;
                        end else begin
                            n_inv = 1'b1;
                        end
                    end else if (r_code == C_MT_TRACK) begin
                        n_pend = 1'b1;
                        if (!r_inv) begin
                            n_act[r_cur_slot] = val_neg ? ACT_RELEASED : ACT_PRESSED;
                        end
                        if (val_neg) begin
                            n_cur_slot = '0;
                            n_inv      = 1'b0;
                        end
                    end
                end
                EVK_SYNC: begin
                    if (r_pend) begin
                        n_pend     = 1'b0;
                        n_walk_idx = SW'(1);
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.emit) begin
            n_act[r_walk_idx] = ACT_IDLE;
        end
        if (i_cmd.step) begin
            n_walk_idx = r_walk_idx + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SLOTS; k++) begin
                r_sx[k]  <= '0;
                r_sy[k]  <= '0;
                r_act[k] <= ACT_IDLE;
            end
            r_cur_slot <= '0;
            r_inv      <= 1'b0;
            r_pend     <= 1'b0;
            r_walk_idx <= SW'(1);
        end else begin
            r_sx       <= n_sx;
            r_sy       <= n_sy;
            r_act      <= n_act;
            r_cur_slot <= n_cur_slot;
            r_inv      <= n_inv;
            r_pend     <= n_pend;
            r_walk_idx <= n_walk_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_contact <= CONTACT_W'(idx_m1);
            r_tstate  <= emit_state;
            r_px      <= r_sx[r_walk_idx];
            r_py      <= r_sy[r_walk_idx];
            r_last    <= !above;
        end
    end

    assign o_sts.sync_go  = (r_kind == EVK_SYNC) && r_pend;
    assign o_sts.hit      = (rd_act != ACT_IDLE);
    assign o_sts.idx_end  = (r_walk_idx == SW'(SLOTS));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_contact_index = r_contact;
    assign o_touch_state   = r_tstate;
    assign o_pos_x         = r_px;
    assign o_pos_y         = r_py;
    assign o_last_in_run   = r_last;

`ifndef NO_ASSERTIONS
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_slot <= SW'(SLOTS))
        else $error("current slot out of range");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> o_out_valid)
        else $error("emitted report not presented");
    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk |-> (r_walk_idx != '0))
        else $error("walk visits the temporary slot");
`endif

endmodule

>>> dv/multitouch_slot_event_decoder_core_test.sv
`timescale 1ns / 100ps

module multitouch_slot_event_decoder_core_test;
    import mtsed_pkg::*;

    localparam int SLOTS         = SLOTS_DEF;
    localparam int SETTLE_CYCLES = SLOTS + 14;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [KIND_W-1:0]  EVK_REL      = 5'd2;
    localparam logic [CODE_W-1:0]  SYN_REPORT   = 10'd0;
    localparam logic [CODE_W-1:0]  BTN_TOOL_PEN = 10'd320;
    localparam logic [SCALE_W-1:0] SCALE_MAX    = 29'h1000_0000;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
    } touch_event_t;

    typedef struct {
        logic [CONTACT_W-1:0] contact;
        logic [1:0]           state;
        logic [POS_W-1:0]     x;
        logic [POS_W-1:0]     y;
        logic                 last;
    } contact_report_t;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index   = CFG_X_SCALE;
    logic [SCALE_W-1:0]          i_cfg_data    = '0;
    logic                        i_in_valid    = 1'b0;
    logic                        o_in_ready;
    logic [KIND_W-1:0]           i_kind        = EVK_SYNC;
    logic [CODE_W-1:0]           i_event_code  = SYN_REPORT;
    logic signed [VALUE_W-1:0]   i_event_value = '0;
    logic                        o_out_valid;
    logic                        i_out_ready   = 1'b0;
    logic [CONTACT_W-1:0]        o_contact_index;
    logic [1:0]                  o_touch_state;
    logic [POS_W-1:0]            o_pos_x;
    logic [POS_W-1:0]            o_pos_y;
    logic                        o_last_in_run;

    // decoder state as predicted
    t_action            slot_act [0:SLOTS];
    logic [POS_W-1:0]   slot_x   [0:SLOTS];
    logic [POS_W-1:0]   slot_y   [0:SLOTS];
    logic [3:0]         sel_slot;
    bit                 sel_invalid;
    bit                 frame_pending;
    logic [SCALE_W-1:0] x_mult;
    logic [SCALE_W-1:0] y_mult;
    bit                 mt_mode;

    touch_event_t    pending_events [$];
    contact_report_t expected_reports [$];
    touch_event_t    next_event;
    contact_report_t head_report;

    int events_queued    = 0;
    int events_accepted  = 0;
    int events_counted   = 0;
    int syncs_sent       = 0;
    int reports_checked  = 0;
    int runs_checked     = 0;
    int settings_applied = 0;
    int mismatch_count   = 0;
    int cycle_count      = 0;
    int send_gap_pct     = 17;
    int recv_gap_pct     = 56;
    int run_phase        = 1;
    int hold_left        = 0;
    bit hold_done        = 1'b0;

    multitouch_slot_event_decoder_core #(
        .SLOTS(SLOTS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_event_code    (i_event_code),
        .i_event_value   (i_event_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_contact_index (o_contact_index),
        .o_touch_state   (o_touch_state),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_last_in_run   (o_last_in_run)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [POS_W-1:0] scaled_pos(logic [SCALE_W-1:0] mult,
                                                    logic [VALUE_W-1:0] raw);
        logic [31:0] prod;
        prod = {3'b000, mult} * raw;
        return prod[SCALE_SHIFT +: POS_W];
    endfunction

    function automatic void set_slot(logic [31:0] s);
        sel_slot    = s[3:0];
        sel_invalid = 1'b0;
    endfunction

    function automatic void store_pos(bit is_y, logic [VALUE_W-1:0] raw);
        if (!sel_invalid && sel_slot <= SLOTS) begin
            if (is_y) begin
                slot_y[sel_slot] = scaled_pos(y_mult, raw);
            end else begin
                slot_x[sel_slot] = scaled_pos(x_mult, raw);
            end
            if (slot_act[sel_slot] == ACT_IDLE) begin
                slot_act[sel_slot] = ACT_POSITION;
            end
        end
        frame_pending = 1'b1;
    endfunction

    function automatic void store_touch(bit pressed);
        if (!sel_invalid && sel_slot <= SLOTS) begin
            if (pressed) begin
                slot_act[sel_slot] = ACT_PRESSED;
            end else begin
                slot_act[sel_slot] = ACT_RELEASED;
            end
        end
        frame_pending = 1'b1;
    endfunction

    function automatic void apply_event(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                        logic [VALUE_W-1:0] raw);
        contact_report_t run [$];
        contact_report_t rep;
        case (kind)
            EVK_KEY: begin
                if (code == C_BTN_TOUCH) begin
                    store_touch(raw != 0);
                    if (raw == 0) begin
                        set_slot(0);
                    end else if (!sel_invalid && sel_slot == 0) begin
                        slot_act[1] = slot_act[0];
                        slot_x[1]   = slot_x[0];
                        slot_y[1]   = slot_y[0];
                        set_slot(1);
                    end
                end
            end
            EVK_ABS: begin
                if ((code == C_ABS_X && !mt_mode) || code == C_MT_POS_X) begin
                    store_pos(1'b0, raw);
                end else if ((code == C_ABS_Y && !mt_mode) || code == C_MT_POS_Y) begin
                    store_pos(1'b1, raw);
                end else if (code == C_MT_SLOT) begin
                    if (raw == '1 || (!raw[31] && raw < SLOTS)) begin
                        set_slot(raw + 1);
                    end else begin
                        sel_invalid = 1'b1;
                    end
                end else if (code == C_MT_TRACK) begin
                    store_touch(!raw[31]);
                    if (raw[31]) begin
                        set_slot(0);
                    end
                end
            end
            EVK_SYNC: begin
                if (frame_pending) begin
                    frame_pending = 1'b0;
                    for (int i = 1; i <= SLOTS; i++) begin
                        if (slot_act[i] != ACT_IDLE) begin
                            rep.contact = CONTACT_W'(i - 1);
                            if (slot_act[i] == ACT_RELEASED) begin
                                rep.state = TS_RELEASED;
                            end else if (slot_act[i] == ACT_PRESSED) begin
                                rep.state = TS_PRESSED;
                            end else begin
                                rep.state = TS_MOTION;
                            end
                            rep.x    = slot_x[i];
                            rep.y    = slot_y[i];
                            rep.last = 1'b0;
                            run.push_back(rep);
                            slot_act[i] = ACT_IDLE;
                        end
                    end
                    if (run.size() > 0) begin
                        run[run.size() - 1].last = 1'b1;
                    end
                    foreach (run[k]) begin
                        expected_reports.push_back(run[k]);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [POS_W-1:0] want,
                                        logic [POS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void add_event(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                      logic [VALUE_W-1:0] value, bit counted = 1'b1);
        touch_event_t ev;
        ev.kind  = kind;
        ev.code  = code;
        ev.value = value;
        pending_events.push_back(ev);
        events_queued++;
        if (counted) begin
            events_counted++;
        end
        if (kind == EVK_SYNC) begin
            syncs_sent++;
        end
    endfunction

    function automatic logic [VALUE_W-1:0] rand_pos();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            return $urandom_range(4095);
        end else if (pick < 90) begin
            return $urandom_range(65535);
        end
        return $urandom;
    endfunction

    function automatic void add_frame(int contacts);
        int pick;
        int slot_val;
        for (int c = 0; c < contacts; c++) begin
            pick = $urandom_range(99);
            if (contacts == SLOTS) begin
                slot_val = c;
            end else if (pick < 85) begin
                slot_val = $urandom_range(SLOTS - 1);
            end else if (pick < 92) begin
                slot_val = -1;
            end else if (pick[0]) begin
                slot_val = $urandom_range(40, SLOTS);
            end else begin
                slot_val = $urandom;
            end
            add_event(EVK_ABS, C_MT_SLOT, slot_val);
            pick = $urandom_range(99);
            if (pick < 40 || contacts == SLOTS) begin
                add_event(EVK_ABS, C_MT_TRACK, $urandom_range(65535));
            end else if (pick < 55) begin
                add_event(EVK_ABS, C_MT_TRACK, -1 - int'($urandom_range(3)));
            end
            if ($urandom_range(99) < 80) begin
                add_event(EVK_ABS, C_MT_POS_X, rand_pos());
            end
            if ($urandom_range(99) < 80) begin
                add_event(EVK_ABS, C_MT_POS_Y, rand_pos());
            end
        end
        pick = $urandom_range(99);
        if (pick < 15) begin
            add_event(EVK_ABS, pick[0] ? C_ABS_X : C_ABS_Y, rand_pos());
        end else if (pick < 25) begin
            add_event(EVK_KEY, C_BTN_TOUCH, pick[0] ? 32'd1 : 32'd0);
        end
        if ($urandom_range(99) < 92) begin
            add_event(EVK_SYNC, SYN_REPORT, 0);
        end
    endfunction

    function automatic void add_random_events(int target);
        int start;
        start = events_counted;
        add_frame(SLOTS);
        while (events_counted - start < target) begin
            if ($urandom_range(99) < 15) begin
                add_event(KIND_W'($urandom_range(31)), CODE_W'($urandom_range(767)),
                          $urandom, 1'b0);
            end else begin
                add_frame($urandom_range(3, 1));
            end
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_X_SCALE: x_mult = data;
            CFG_Y_SCALE: y_mult = data;
            CFG_MT_MODE: mt_mode = data[0];
            default: begin
            end
        endcase
    endtask

    task automatic program_regs(logic [SCALE_W-1:0] xs, logic [SCALE_W-1:0] ys, bit mode);
        write_reg(CFG_X_SCALE, xs);
        write_reg(CFG_Y_SCALE, ys);
        write_reg(CFG_MT_MODE, {{(SCALE_W - 1){1'b0}}, mode});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic drain();
        while (events_accepted != events_queued) @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_event(i_kind, i_event_code, i_event_value);
                events_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_event = pending_events.pop_front();
                    i_in_valid    <= 1'b1;
                    i_kind        <= next_event.kind;
                    i_event_code  <= next_event.code;
                    i_event_value <= next_event.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("contact report with none expected: contact_index %0d",
                           o_contact_index);
                    mismatch_count++;
                end else begin
                    head_report = expected_reports.pop_front();
                    check_field("contact_index", POS_W'(head_report.contact),
                                POS_W'(o_contact_index));
                    check_field("touch_state", POS_W'(head_report.state),
                                POS_W'(o_touch_state));
                    check_field("pos_x", head_report.x, o_pos_x);
                    check_field("pos_y", head_report.y, o_pos_y);
                    check_field("last_in_run", POS_W'(head_report.last),
                                POS_W'(o_last_in_run));
                    reports_checked++;
                    if (head_report.last) begin
                        runs_checked++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (run_phase == 3 && !hold_done && o_out_valid) begin
                // stall the output long enough to back up the input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("multitouch_slot_event_decoder_core test failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i <= SLOTS; i++) begin
            slot_act[i] = ACT_IDLE;
            slot_x[i]   = '0;
            slot_y[i]   = '0;
        end
        sel_slot      = '0;
        sel_invalid   = 1'b0;
        frame_pending = 1'b0;
        x_mult        = '0;
        y_mult        = '0;
        mt_mode       = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_regs(SCALE_MAX, 29'd4096, 1'b0);
        add_event(EVK_SYNC, SYN_REPORT, 0);
        add_event(EVK_ABS, C_ABS_X, 32'h7FFF_FFFF);
        add_event(EVK_ABS, C_ABS_Y, 32'h8000_0000);
        add_event(EVK_KEY, C_BTN_TOUCH, 1);
        add_event(EVK_SYNC, SYN_REPORT, 0);
        add_event(EVK_KEY, BTN_TOOL_PEN, 1);
        add_event(EVK_REL, C_MT_POS_X, 5);
        add_event(EVK_ABS, C_MT_SLOT, -1);
        add_event(EVK_ABS, C_MT_SLOT, SLOTS - 1);
        add_event(EVK_ABS, C_MT_TRACK, 32'h7FFF_FFFF);
        add_event(EVK_ABS, C_MT_POS_X, 32'hFFFF_FFFF);
        add_event(EVK_ABS, C_MT_POS_Y, 0);
        add_event(EVK_ABS, C_MT_SLOT, SLOTS);
        add_event(EVK_ABS, C_MT_POS_X, 1234);
        add_event(EVK_ABS, C_MT_TRACK, -1);
        add_event(EVK_ABS, C_MT_SLOT, 32'h8000_0000);
        add_event(EVK_KEY, C_BTN_TOUCH, 0);
        add_event(EVK_ABS, C_MT_SLOT, 2);
        add_event(EVK_ABS, C_MT_POS_Y, 100);
        add_event(EVK_ABS, C_MT_SLOT, 0);
        add_event(EVK_ABS, C_MT_TRACK, 32'h8000_0000);
        add_event(EVK_SYNC, SYN_REPORT, 0);
        add_event(EVK_SYNC, SYN_REPORT, 0);
        add_event(EVK_ABS, C_MT_SLOT, -2);
        add_event(EVK_KEY, C_BTN_TOUCH, 32'hFFFF_FFFF);
        add_event(EVK_SYNC, SYN_REPORT, 0);
        drain();

        program_regs(SCALE_W'($urandom_range(SCALE_MAX, 1)), SCALE_MAX, 1'b0);
        add_random_events(45);
        drain();

        run_phase    = 2;
        send_gap_pct = 56;
        recv_gap_pct = 17;
        program_regs(SCALE_W'($urandom_range(SCALE_MAX, 1)), '0, 1'b1);
        add_random_events(40);
        drain();

        run_phase    = 3;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        program_regs('0, SCALE_W'($urandom_range(SCALE_MAX, 1)), 1'b0);
        add_random_events(40);
        drain();

        if (expected_reports.size() != 0) begin
            $error("%0d contact reports never arrived", expected_reports.size());
            mismatch_count++;
        end
        $display("Sent %0d events (%0d syncs) over %0d register settings and three idle mixes",
                 events_queued, syncs_sent, settings_applied);
        $display("Checked %0d contact reports in %0d runs, with one %0d-cycle output stall",
                 reports_checked, runs_checked, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("multitouch_slot_event_decoder_core test passed");
        end else begin
            $display("multitouch_slot_event_decoder_core test failed");
        end
        $finish;
    end

endmodule
